/* sv/id3p_pkg.sv */
// id3p_pkg: shared types and constants for the id3v2 tag frame parser
// used by id3p_front, id3p_back and the top level
`default_nettype none
package id3p_pkg;
	localparam int TEXT_LIMIT_DEF = 64;
	localparam logic [7:0] WANTED_PIC_RST = 8'd3;

	typedef enum logic [2:0] {
		EV_TITLE_CHAR  = 3'd0,
		EV_ARTIST_CHAR = 3'd1,
		EV_COVER_BYTE  = 3'd2,
		EV_TITLE_CLR   = 3'd3,
		EV_ARTIST_CLR  = 3'd4,
		EV_TAG_END     = 3'd5
	} ev_kind_t;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_BADMRK = 3'd1,
		ST_EXTHDR = 3'd2,
		ST_UNSYNC = 3'd3,
		ST_V22    = 3'd4
	} end_st_t;

	typedef enum logic [11:0] {
		PH_HEADER = 12'b000000000001,
		PH_FHDR   = 12'b000000000010,
		PH_ENC    = 12'b000000000100,
		PH_TEXT   = 12'b000000001000,
		PH_MIME   = 12'b000000010000,
		PH_PTYPE  = 12'b000000100000,
		PH_DESC8  = 12'b000001000000,
		PH_DESC16 = 12'b000010000000,
		PH_IMAGE  = 12'b000100000000,
		PH_SKIP   = 12'b001000000000,
		PH_PAD    = 12'b010000000000,
		PH_DONE   = 12'b100000000000
	} phase_t;

	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0, CLS_ARTIST = 2'd1, CLS_TITLE = 2'd2, CLS_PICTURE = 2'd3
	} fclass_t;

	// one classified byte: up to two results
	typedef struct packed {
		logic     v0;
		ev_kind_t k0;
		logic [7:0] b0;
		end_st_t  s0;
		logic     v1;
		ev_kind_t k1;
		end_st_t  s1;
	} pair_t;

	typedef struct packed {
		ev_kind_t kind;
		logic [7:0] data;
		end_st_t st;
		logic last;
	} event_t;

	localparam logic [31:0] ID_APIC = 32'h41504943;
	localparam logic [31:0] ID_TPE1 = 32'h54504531;
	localparam logic [31:0] ID_TIT2 = 32'h54495432;
endpackage
`default_nettype wire

/* sv/id3p_front.sv */
// id3p_front: byte-at-a-time tag parser state, classifies each byte into result pairs
// depends on id3p_pkg
`default_nettype none
module id3p_front #(
	parameter int TEXT_LIMIT = id3p_pkg::TEXT_LIMIT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_ok,
	input  wire logic [7:0] tag_byte,
	input  wire logic tag_start,
	input  wire logic [7:0] wanted_pic,
	output id3p_pkg::pair_t pair_s1,
	output logic pair_vld_s1
);
	import id3p_pkg::*;
	localparam int TW = $clog2(TEXT_LIMIT + 1) < 4 ? 4 : $clog2(TEXT_LIMIT + 1);

	phase_t ph_q, ph;
	logic [32:0] pos_q, pos;
	logic [27:0] len_q, len;
	logic [7:0] maj_q, maj;
	logic [31:0] fid_q, fid, flen_q, flen, fsz;
	logic [32:0] fend_q, fend, bp1;
	logic [7:0] enc_q, enc, pk_q, pk;
	fclass_t cls_q, cls;
	logic [TW-1:0] cnt_q, cnt;
	logic phz_q, phz, cov_q, cov;
	pair_t pr;
	logic [2:0] bad;
	logic in_frame;
	logic [33:0] fsum;

	always_comb begin
		ph = ph_q; pos = pos_q; len = len_q; maj = maj_q; fid = fid_q; flen = flen_q;
		fend = fend_q; enc = enc_q; pk = pk_q; cls = cls_q; cnt = cnt_q;
		phz = phz_q; cov = cov_q;
		pr = '0; bad = 3'd0; in_frame = 1'b1; fsz = '0; fsum = '0;
		if (tag_start) begin
			ph = PH_HEADER; pos = '0; len = '0; maj = '0; fid = '0; flen = '0;
			fend = '0; enc = '0; pk = '0; cls = CLS_OTHER; cnt = '0; phz = 1'b0;
			cov = 1'b0;
		end
		bp1 = pos - 33'd9;
		if (ph == PH_HEADER) begin
			priority if (pos == 33'd0 && tag_byte != 8'h49) bad = ST_BADMRK;
			else if (pos == 33'd1 && tag_byte != 8'h44) bad = ST_BADMRK;
			else if (pos == 33'd2 && tag_byte != 8'h33) bad = ST_BADMRK;
			else if (pos == 33'd3) maj = tag_byte;
			else if (pos == 33'd5) begin
				priority if (tag_byte[6] && maj >= 8'd3) bad = ST_EXTHDR;
				else if (tag_byte[7]) bad = ST_UNSYNC;
				else if (maj == 8'd2) bad = ST_V22;
			end else if (pos >= 33'd6) len = {len[20:0], tag_byte[6:0]};
			if (pos == 33'd9) begin
				if (len >= 28'd10) begin
					ph = PH_FHDR; cnt = '0; fid = '0; flen = '0;
				end else ph = PH_PAD;
			end
		end else if (ph != PH_DONE) begin
			unique case (ph)
				PH_FHDR: begin
					in_frame = 1'b0;
					if (cnt < TW'(4)) fid = {fid[23:0], tag_byte};
					else if (cnt < TW'(8)) flen = {flen[23:0], tag_byte};
					cnt = cnt + TW'(1);
					if (cnt >= TW'(10)) begin
						fsz = (maj == 8'd4) ? {4'd0, flen[30:24], flen[22:16], flen[14:8],
							flen[6:0]} : flen;
						flen = fsz; cnt = '0;
						fsum = {1'b0, bp1} + {2'b0, fsz};
						if (fsz == '0 || fsum > {6'd0, len}) ph = PH_PAD;
						else begin
							fend = fsum[32:0];
							if (fid == ID_APIC) cls = CLS_PICTURE;
							else if (fid == ID_TPE1) cls = CLS_ARTIST;
							else if (fid == ID_TIT2) cls = CLS_TITLE;
							else cls = CLS_OTHER;
							if (cls == CLS_ARTIST) begin pr.v0 = 1'b1; pr.k0 = EV_ARTIST_CLR; end
							if (cls == CLS_TITLE) begin pr.v0 = 1'b1; pr.k0 = EV_TITLE_CLR; end
							ph = PH_ENC;
						end
					end
				end
				PH_ENC: begin
					enc = tag_byte;
					if (cls == CLS_PICTURE) ph = PH_MIME;
					else if (cls == CLS_OTHER) ph = PH_SKIP;
					else ph = PH_TEXT;
				end
				PH_TEXT: begin
					if (tag_byte == 8'd0) ph = PH_SKIP;
					else if (cnt < TW'(TEXT_LIMIT)) begin
						pr.v0 = 1'b1;
						pr.k0 = (cls == CLS_TITLE) ? EV_TITLE_CHAR : EV_ARTIST_CHAR;
						pr.b0 = tag_byte; cnt = cnt + TW'(1);
					end
				end
				PH_MIME: if (tag_byte == 8'd0) ph = PH_PTYPE;
				PH_PTYPE: begin
					pk = tag_byte; cnt = '0; phz = 1'b0;
					ph = (enc == 8'd0 || enc == 8'd3) ? PH_DESC8 : PH_DESC16;
				end
				PH_DESC8: if (tag_byte == 8'd0)
					ph = (!cov && pk == wanted_pic) ? PH_IMAGE : PH_SKIP;
				PH_DESC16: begin
					if (!cnt[0]) begin
						phz = (tag_byte == 8'd0); cnt = TW'(1);
					end else begin
						cnt = '0;
						if (phz && tag_byte == 8'd0)
							ph = (!cov && pk == wanted_pic) ? PH_IMAGE : PH_SKIP;
					end
				end
				PH_IMAGE: begin
					pr.v0 = 1'b1; pr.k0 = EV_COVER_BYTE; pr.b0 = tag_byte; cov = 1'b1;
				end
				PH_SKIP: ;
				default: in_frame = 1'b0;
			endcase
			if (in_frame && bp1 == fend) begin
				if (bp1 <= {5'd0, len} && ({5'd0, len} - bp1) >= 33'd10) begin
					ph = PH_FHDR; cnt = '0; fid = '0; flen = '0;
				end else ph = PH_PAD;
			end
		end
		if (bad != 3'd0) begin
			pr.v0 = 1'b1; pr.k0 = EV_TAG_END; pr.b0 = '0; pr.s0 = end_st_t'(bad);
			ph = PH_DONE;
		end else if (ph_q != PH_DONE || tag_start) begin
			if (ph != PH_HEADER && ph != PH_DONE && pos == 33'd9 + {5'd0, len}) begin
				// tag end goes in the free slot
				if (pr.v0) begin pr.v1 = 1'b1; pr.k1 = EV_TAG_END; pr.s1 = ST_OK; end
				else begin pr.v0 = 1'b1; pr.k0 = EV_TAG_END; pr.b0 = '0; pr.s0 = ST_OK; end
				ph = PH_DONE;
			end
		end
		if (!(ph_q == PH_DONE && !tag_start) && bad == 3'd0) pos = pos + 33'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_HEADER; pos_q <= '0; len_q <= '0; maj_q <= '0; fid_q <= '0;
			flen_q <= '0; fend_q <= '0; enc_q <= '0; pk_q <= '0; cls_q <= CLS_OTHER;
			cnt_q <= '0; phz_q <= 1'b0; cov_q <= 1'b0; pair_vld_s1 <= 1'b0;
		end else begin
			pair_vld_s1 <= in_ok && pr.v0;
			if (in_ok) begin
				ph_q <= ph; pos_q <= pos; len_q <= len; maj_q <= maj; fid_q <= fid;
				flen_q <= flen; fend_q <= fend; enc_q <= enc; pk_q <= pk; cls_q <= cls;
				cnt_q <= cnt; phz_q <= phz; cov_q <= cov;
			end
		end
	end

	always_ff @(posedge clk) if (in_ok) pair_s1 <= pr;
endmodule
`default_nettype wire

/* sv/id3p_back.sv */
// id3p_back: pair queue between front and result port, splits pairs into single items
// depends on id3p_pkg
`default_nettype none
module id3p_back (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic wr,
	input  id3p_pkg::pair_t wdata,
	output logic room,
	output logic [1:0] used,
	input  wire logic pop,
	output logic empty,
	output id3p_pkg::event_t head
);
	import id3p_pkg::*;
	localparam int DEPTH = 4;
	pair_t mem_q [DEPTH];
	logic [1:0] rd_q, wr_q;
	logic [2:0] cnt_q;
	logic half_q, take, done;

	assign used = cnt_q[1:0];
	// need two free entries: one may be in flight from the front
	assign room = cnt_q <= 3'd2;
	assign empty = cnt_q == 3'd0;
	always_comb begin
		if (!half_q) begin
			head.kind = mem_q[rd_q].k0; head.data = mem_q[rd_q].b0;
			head.st = mem_q[rd_q].s0; head.last = !mem_q[rd_q].v1;
		end else begin
			head.kind = mem_q[rd_q].k1; head.data = '0;
			head.st = mem_q[rd_q].s1; head.last = 1'b1;
		end
	end
	assign take = pop && !empty;
	assign done = take && head.last;

	always_ff @(posedge clk) if (wr) mem_q[wr_q] <= wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0; wr_q <= '0; cnt_q <= '0; half_q <= 1'b0;
		end else begin
			if (wr) wr_q <= wr_q + 2'd1;
			if (done) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr} - {2'd0, done};
			if (take) half_q <= !head.last;
		end
	end
endmodule
`default_nettype wire

/* sv/id3v2_tag_frame_parser_unit.sv */
// id3v2_tag_frame_parser_unit: top level, front parser plus back result queue
// depends on id3p_pkg, id3p_front, id3p_back
//
// channel   dir  handshake          payload
// tag in    in   push / full        tag_byte, tag_start
// events    out  empty / pop        event_kind, event_byte, end_status, last_event
// config    in   cfg_valid / ready  cfg_data (wanted picture type)
//
// one byte a cycle while full is low; the front updates parse state in the accepting cycle
// a byte's results are registered by the front, then written into the pair queue,
// and leave it one per cycle while pop is held, two for a byte at most
// full rises when the 4-pair queue between front and back holds three pairs
// reset is asynchronous; the picture type resets to front cover
`default_nettype none
module id3v2_tag_frame_parser_unit #(
	parameter int TEXT_LIMIT = id3p_pkg::TEXT_LIMIT_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	output logic full,
	input  wire logic [7:0] tag_byte,
	input  wire logic tag_start,
	output logic empty,
	input  wire logic pop,
	output logic [2:0] event_kind,
	output logic [7:0] event_byte,
	output logic [2:0] end_status,
	output logic last_event,
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [7:0] cfg_data
);
	import id3p_pkg::*;
	logic [7:0] wanted_q;
	logic in_ok, pv, room;
	logic [1:0] used;
	pair_t pr;
	event_t head;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) wanted_q <= WANTED_PIC_RST;
		else if (cfg_valid) wanted_q <= cfg_data;
	end

	assign full = !room;
	assign in_ok = push && room;

	id3p_front #(.TEXT_LIMIT(TEXT_LIMIT)) u_front (
		.clk, .arst_n, .in_ok, .tag_byte, .tag_start, .wanted_pic(wanted_q),
		.pair_s1(pr), .pair_vld_s1(pv)
	);
	id3p_back u_back (
		.clk, .arst_n, .wr(pv), .wdata(pr), .room, .used, .pop, .empty, .head
	);

	assign event_kind = head.kind;
	assign event_byte = head.data;
	assign end_status = head.st;
	assign last_event = head.last;

	a_tag_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind == EV_TAG_END) |-> last_event) else $error("tag end not last");
	a_full_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(used == 2'd3) |-> full) else $error("queue full not flagged");
	a_end_status: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && event_kind != EV_TAG_END) |-> end_status == ST_OK)
		else $error("status on non end item");
endmodule
`default_nettype wire

/* tb/sv/tb_id3v2_tag_frame_parser_unit.sv */
// tb_id3v2_tag_frame_parser_unit: self-checking bench for the id3v2 tag frame parser
// depends on id3p_pkg and id3v2_tag_frame_parser_unit; predicts events per tag byte
`default_nettype none
module tb_id3v2_tag_frame_parser_unit;
	import id3p_pkg::*;

	localparam int TLIM = 64;

	typedef enum logic [3:0] {
		S_HDR, S_FHDR, S_ENC, S_TEXT, S_MIME, S_PTYPE, S_DESC8, S_DESC16,
		S_IMAGE, S_SKIP, S_PAD, S_DONE
	} pstate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [7:0] tag_byte = 8'd0;
	logic tag_start = 1'b0;
	logic pop = 1'b0;
	logic cfg_valid = 1'b0;
	logic [7:0] cfg_data = 8'd0;
	logic full, empty, cfg_ready, last_event;
	logic [2:0] event_kind, end_status;
	logic [7:0] event_byte;

	id3v2_tag_frame_parser_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.tag_byte(tag_byte), .tag_start(tag_start), .empty(empty), .pop(pop),
		.event_kind(event_kind), .event_byte(event_byte), .end_status(end_status),
		.last_event(last_event), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// parser copy
	logic [7:0] want_pic;
	pstate_t ph;
	logic [32:0] pos;
	logic [27:0] tlen;
	logic [7:0] major;
	logic [31:0] fid, flen;
	logic [32:0] fend;
	logic [7:0] enc, pic;
	fclass_t cls;
	logic [6:0] tcnt;
	logic half0, cover_done;

	event_t pending_events[$];
	int errors = 0;
	int hold_cycles = 0;
	bit sink_random = 1'b1;

	task automatic clear_parser();
		ph = S_HDR; pos = '0; tlen = '0; major = '0; fid = '0; flen = '0;
		fend = '0; enc = '0; pic = '0; cls = CLS_OTHER; tcnt = '0;
		half0 = 1'b0; cover_done = 1'b0;
	endtask

	function automatic void add_event(ev_kind_t k, logic [7:0] d, end_st_t s);
		event_t e;
		e.kind = k; e.data = d; e.st = s; e.last = 1'b0;
		pending_events.push_back(e);
	endfunction

	task automatic frame_or_pad(logic [32:0] p);
		if (p <= {5'd0, tlen} && {5'd0, tlen} - p >= 33'd10) begin
			ph = S_FHDR; tcnt = '0; fid = '0; flen = '0;
		end else
			ph = S_PAD;
	endtask

	task automatic pick_image();
		ph = (!cover_done && pic == want_pic) ? S_IMAGE : S_SKIP;
	endtask

	task automatic predict_byte(logic [7:0] b, logic st);
		int n0;
		logic [32:0] bp, npos;
		logic [31:0] fs;
		end_st_t bad;
		bit in_frame;
		n0 = pending_events.size();
		bad = ST_OK;
		in_frame = 1'b1;
		if (st) clear_parser();
		if (ph == S_DONE) return;
		if (ph == S_HDR) begin
			if (pos == 0 && b != "I") bad = ST_BADMRK;
			else if (pos == 1 && b != "D") bad = ST_BADMRK;
			else if (pos == 2 && b != "3") bad = ST_BADMRK;
			else if (pos == 3) major = b;
			else if (pos == 5) begin
				if (b[6] && major >= 3) bad = ST_EXTHDR;
				else if (b[7]) bad = ST_UNSYNC;
				else if (major == 2) bad = ST_V22;
			end else if (pos >= 6)
				tlen = {tlen[20:0], b[6:0]};
			if (bad != ST_OK) begin
				add_event(EV_TAG_END, 8'd0, bad);
				pending_events[$].last = 1'b1;
				ph = S_DONE;
				return;
			end
			if (pos == 9) frame_or_pad(33'd0);
		end else begin
			bp = pos - 33'd10;
			case (ph)
				S_FHDR: begin
					in_frame = 1'b0;
					if (tcnt < 4) fid = {fid[23:0], b};
					else if (tcnt < 8) flen = {flen[23:0], b};
					tcnt++;
					if (tcnt >= 10) begin
						npos = bp + 33'd1;
						fs = (major == 8'd4) ? {4'd0, flen[30:24], flen[22:16],
							flen[14:8], flen[6:0]} : flen;
						flen = fs;
						tcnt = '0;
						if (fs == 0 || npos + {1'b0, fs} > {5'd0, tlen})
							ph = S_PAD;
						else begin
							fend = npos + {1'b0, fs};
							if (fid == ID_APIC) cls = CLS_PICTURE;
							else if (fid == ID_TPE1) cls = CLS_ARTIST;
							else if (fid == ID_TIT2) cls = CLS_TITLE;
							else cls = CLS_OTHER;
							if (cls == CLS_ARTIST) add_event(EV_ARTIST_CLR, 8'd0, ST_OK);
							if (cls == CLS_TITLE) add_event(EV_TITLE_CLR, 8'd0, ST_OK);
							ph = S_ENC;
						end
					end
				end
				S_ENC: begin
					enc = b;
					if (cls == CLS_PICTURE) ph = S_MIME;
					else if (cls == CLS_OTHER) ph = S_SKIP;
					else ph = S_TEXT;
				end
				S_TEXT: begin
					if (b == 0) ph = S_SKIP;
					else if (tcnt < TLIM) begin
						add_event(cls == CLS_TITLE ? EV_TITLE_CHAR : EV_ARTIST_CHAR, b, ST_OK);
						tcnt++;
					end
				end
				S_MIME: if (b == 0) ph = S_PTYPE;
				S_PTYPE: begin
					pic = b; tcnt = '0; half0 = 1'b0;
					ph = (enc == 0 || enc == 3) ? S_DESC8 : S_DESC16;
				end
				S_DESC8: if (b == 0) pick_image();
				S_DESC16: begin
					if (!tcnt[0]) begin
						half0 = (b == 0); tcnt = 7'd1;
					end else begin
						tcnt = '0;
						if (half0 && b == 0) pick_image();
					end
				end
				S_IMAGE: begin
					add_event(EV_COVER_BYTE, b, ST_OK);
					cover_done = 1'b1;
				end
				S_SKIP: ;
				default: in_frame = 1'b0;
			endcase
			if (in_frame && bp + 33'd1 == fend) frame_or_pad(bp + 33'd1);
		end
		if (ph != S_HDR && pos == 33'd9 + {5'd0, tlen}) begin
			add_event(EV_TAG_END, 8'd0, ST_OK);
			ph = S_DONE;
		end
		pos++;
		if (pending_events.size() > n0) pending_events[$].last = 1'b1;
	endtask

	// sends one tag byte after a random gap; push stays high between back to back items
	task automatic send_byte(logic [7:0] b, logic st = 1'b0);
		int gap;
		gap = $urandom_range(0, 9) * ($urandom_range(0, 3) != 0 ? 1 : 0);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1; tag_byte <= b; tag_start <= st;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_byte(b, st);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		push <= 1'b0;
		while (pending_events.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	task automatic write_pic_type(logic [7:0] v);
		cfg_valid <= 1'b1; cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		want_pic = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// tag header: mark, version, revision, flags, syncsafe size
	task automatic send_header(logic [7:0] ver, logic [7:0] flg, int size);
		send_byte("I", 1'b1); send_byte("D"); send_byte("3");
		send_byte(ver); send_byte(8'd0); send_byte(flg);
		send_byte({1'b0, 7'(size >> 21)}); send_byte({1'b0, 7'(size >> 14)});
		send_byte({1'b0, 7'(size >> 7)}); send_byte({1'b0, 7'(size)});
	endtask

	task automatic send_frame_hdr(logic [31:0] id, logic [7:0] ver, int size);
		logic [31:0] sz;
		sz = (ver == 8'd4) ? {1'b0, 7'(size >> 21), 1'b0, 7'(size >> 14),
			1'b0, 7'(size >> 7), 1'b0, 7'(size)} : size;
		for (int i = 3; i >= 0; i--) send_byte(id[i*8 +: 8]);
		for (int i = 3; i >= 0; i--) send_byte(sz[i*8 +: 8]);
		send_byte(8'($urandom_range(0, 255))); send_byte(8'($urandom_range(0, 255)));
	endtask

	// tag with a valid header and random frames and content
	task automatic send_random_tag();
		logic [7:0] ver;
		int body, used, nf, fs, kind, tl;
		logic [31:0] id;
		ver = ($urandom_range(0, 1) != 0) ? 8'd4 : 8'd3;
		nf = $urandom_range(1, 4);
		body = $urandom_range(20, 90);
		send_header(ver, 8'($urandom_range(0, 1) << 5), body + $urandom_range(0, 1) * 3);
		used = 0;
		for (int f = 0; f < nf && used + 12 <= body; f++) begin
			kind = $urandom_range(0, 3);
			id = kind == 0 ? ID_TIT2 : kind == 1 ? ID_TPE1 : kind == 2 ? ID_APIC : 32'h434f4d4d;
			fs = $urandom_range(1, body - used - 10);
			send_frame_hdr(id, ver, fs);
			used += 10 + fs;
			for (int i = 0; i < fs; i++) begin
				if (kind == 2) begin
					// encoding, mime, type, description, image
					case (i)
						0: send_byte(8'($urandom_range(0, 3)));
						1, 2: send_byte("a");
						3: send_byte(8'd0);
						4: send_byte($urandom_range(0, 1) ? want_pic : 8'($urandom_range(0, 255)));
						5, 6: send_byte(8'd0);
						default: send_byte(8'($urandom_range(0, 255)));
					endcase
				end else if (i == 0)
					send_byte(8'($urandom_range(0, 3)));
				else
					send_byte($urandom_range(0, 15) == 0 ? 8'd0 : 8'($urandom_range(1, 255)));
			end
		end
		tl = body - used + $urandom_range(0, 4);
		for (int i = 0; i < tl; i++)
			send_byte($urandom_range(0, 7) == 0 ? 8'd0 : 8'($urandom_range(0, 255)));
	endtask

	task automatic test_header_errors();
		send_byte("X");
		send_byte("I", 1'b1); send_byte("Q");
		send_byte(8'hff);
		send_byte("I", 1'b1); send_byte("D"); send_byte("4");
		send_header(8'd3, 8'h40, 20);
		send_header(8'd4, 8'h80, 20);
		send_header(8'd2, 8'h00, 20);
		send_header(8'd9, 8'h00, 0);
		wait_drain();
	endtask

	task automatic test_text_frames();
		send_header(8'd4, 8'h00, 200);
		send_frame_hdr(ID_TIT2, 8'd4, 80);
		send_byte(8'd0);
		for (int i = 0; i < 79; i++) send_byte(8'($urandom_range(1, 255)) | 8'h80);
		send_frame_hdr(ID_TPE1, 8'd4, 5);
		send_byte(8'd3); send_byte("a"); send_byte(8'd0); send_byte("b"); send_byte("c");
		send_frame_hdr(ID_TIT2, 8'd3, 0);
		for (int i = 0; i < 95; i++) send_byte(8'h55);
		wait_drain();
	endtask

	task automatic test_picture();
		send_header(8'd3, 8'h00, 60);
		send_frame_hdr(ID_APIC, 8'd3, 12);
		send_byte(8'd1); send_byte("i"); send_byte(8'd0); send_byte(want_pic);
		send_byte("d"); send_byte(8'd0); send_byte(8'd0); send_byte(8'd0);
		send_byte(8'hde); send_byte(8'had); send_byte(8'h00); send_byte(8'hff);
		send_frame_hdr(ID_APIC, 8'd3, 6);
		send_byte(8'd0); send_byte(8'd0); send_byte(want_pic); send_byte(8'd0);
		send_byte(8'h11); send_byte(8'h22);
		send_frame_hdr(ID_APIC, 8'd3, 100);
		for (int i = 0; i < 22; i++) send_byte(8'h00);
		send_byte(8'h42);
		wait_drain();
	endtask

	task automatic test_random_tags();
		for (int t = 0; t < 9; t++) begin
			if (t % 4 == 3) begin
				wait_drain();
				write_pic_type(t == 7 ? 8'hff : 8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 5) == 0)
				send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			send_random_tag();
		end
		wait_drain();
	endtask

	task automatic test_backpressure();
		send_header(8'd3, 8'h00, 30);
		send_frame_hdr(ID_TIT2, 8'd3, 20);
		// sink holds off while the text bytes keep coming
		hold_cycles = 60;
		for (int i = 0; i < 20; i++) send_byte("z");
		wait_drain();
	endtask

	// result sink
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			pop <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else
			pop <= sink_random ? ($urandom_range(0, 9) < 6) : 1'b1;
	end

	always @(posedge clk) begin
		event_t exp_ev;
		if (arst_n && pop && !empty) begin
			if (pending_events.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected event kind %0d byte %0h", event_kind, event_byte);
			end else begin
				exp_ev = pending_events.pop_front();
				if (event_kind != exp_ev.kind || event_byte != exp_ev.data ||
						end_status != exp_ev.st || last_event != exp_ev.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch exp k%0d b%0h s%0d l%0d got k%0d b%0h s%0d l%0d",
							exp_ev.kind, exp_ev.data, exp_ev.st, exp_ev.last,
							event_kind, event_byte, end_status, last_event);
				end
			end
		end
	end

	initial begin
		#3000000;
		$display("Verification failed");
		$finish;
	end

	initial begin
		want_pic = WANTED_PIC_RST;
		clear_parser();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_header_errors();
		test_picture();
		write_pic_type(8'd0);
		test_picture();
		test_text_frames();
		test_backpressure();
		test_random_tags();
		write_pic_type(8'd3);
		wait_drain();
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

/* id3v2_tag_frame_parser_unit.f */
sv/id3p_pkg.sv
sv/id3p_front.sv
sv/id3p_back.sv
sv/id3v2_tag_frame_parser_unit.sv
tb/sv/tb_id3v2_tag_frame_parser_unit.sv
